### sv/mtpa_pkg.sv
// Shared types, widths and helpers for the MTPA current reference block.
`default_nettype none
package mtpa_pkg;

	localparam int CUR_W  = 24;
	localparam int FLUX_W = 31;
	localparam int IND_W  = 40;
	localparam int CFG_W  = 40;
	localparam int IDX_W  = 2;

	// flux in nWb times this gives femtowebers
	localparam int SCALE_W = 20;
	localparam logic [SCALE_W-1:0] FLUX_SCALE = 20'd1000000;

	localparam int F_W   = FLUX_W + SCALE_W;
	localparam int FH_W  = F_W - 32;
	localparam int FSQ_W = 2 * F_W;
	localparam int DH_W  = IND_W - 32;
	localparam int P_W   = IND_W + CUR_W;
	localparam int PH_W  = P_W - 32;
	localparam int P2_W  = 2 * P_W;
	localparam int T_W   = 2 * P_W + 4;
	localparam int S_W   = T_W / 2;
	localparam int SR_W  = S_W + 2;
	localparam int DEN_W = IND_W + 2;
	localparam int DV_W  = (S_W > DEN_W + CUR_W - 1) ? S_W : DEN_W + CUR_W - 1;
	localparam int R2_W  = 2 * CUR_W;
	localparam int RR_W  = CUR_W + 2;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_FLUX = 2'd1,
		REG_LD   = 2'd2,
		REG_LQ   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_MTPA = 2'd0,
		K_PASS = 2'd1,
		K_ZERO = 2'd2
	} kind_t;

	typedef struct packed {
		logic             neg;
		logic [CUR_W-1:0] mag;
		kind_t            kind;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [F_W-1:0]   f;
		logic [IND_W-1:0] dl;
	} carry_t;

	// one restoring square root step: bring in two radicand bits, try root*4+1
	function automatic logic [SR_W+S_W-1:0] sqrt_step(input logic [SR_W-1:0] rem,
			input logic [S_W-1:0] root, input logic [1:0] pair);
		logic [SR_W-1:0] r2;
		logic [SR_W-1:0] trial;
		r2    = {rem[SR_W-3:0], pair};
		trial = {root, 2'b01};
		if (r2 >= trial) begin
			sqrt_step = {r2 - trial, root[S_W-2:0], 1'b1};
		end else begin
			sqrt_step = {r2, root[S_W-2:0], 1'b0};
		end
	endfunction

endpackage
`default_nettype wire

### sv/mtpa_wide_sqrt.sv
// Pipelined floor square root of the wide MTPA radicand, one root bit per stage.
`default_nettype none
module mtpa_wide_sqrt
	import mtpa_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire carry_t         in_car,
	input  wire logic [T_W-1:0] rad,
	output logic                out_vld,
	output carry_t              out_car,
	output logic [S_W-1:0]      root
);

	logic            vld_s  [S_W];
	carry_t          car_s  [S_W];
	logic [T_W-1:0]  rad_s  [S_W];
	logic [SR_W-1:0] rem_s  [S_W];
	logic [S_W-1:0]  root_s [S_W];

	for (genvar k = 0; k < S_W; k++) begin : g_st
		logic            vi;
		carry_t          ci;
		logic [T_W-1:0]  ri;
		logic [SR_W-1:0] mi;
		logic [S_W-1:0]  qi;
		logic [SR_W+S_W-1:0] nx;

		if (k == 0) begin : g_first
			assign vi = in_vld;
			assign ci = in_car;
			assign ri = rad;
			assign mi = '0;
			assign qi = '0;
		end else begin : g_next
			assign vi = vld_s[k-1];
			assign ci = car_s[k-1];
			assign ri = rad_s[k-1];
			assign mi = rem_s[k-1];
			assign qi = root_s[k-1];
		end

		assign nx = sqrt_step(mi, qi, ri[T_W-1 -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				car_s[k]  <= ci;
				rad_s[k]  <= {ri[T_W-3:0], 2'b00};
				rem_s[k]  <= nx[S_W +: SR_W];
				root_s[k] <= nx[S_W-1:0];
			end
		end
	end

	assign out_vld = vld_s[S_W-1];
	assign out_car = car_s[S_W-1];
	assign root    = root_s[S_W-1];

endmodule
`default_nettype wire

### sv/mtpa_current_reference.sv
// Top level of the MTPA current reference pipeline.
// One current target enters per clock and its d/q references are built in turn:
// six stages of split multiplies and adds build the radicand, a 66-stage
// square root unit takes one root bit per stage, a 24-stage restoring divider
// takes one quotient bit per stage, and three clamp, multiply and subtract stages plus a
// 24-stage square root give the q current. Throughput is one transaction per
// cycle; the whole pipeline holds while the output transaction is not taken.
// Mode, flux and inductance registers are to be written only while no
// transaction is in flight.
`default_nettype none
module mtpa_current_reference
	import mtpa_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [IDX_W-1:0]        cfg_idx,
	input  wire logic [CFG_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [CUR_W-1:0] current_target,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [CUR_W-1:0]      id_ref,
	output logic signed [CUR_W-1:0]      iq_ref
);

	logic              mode_q;
	logic [FLUX_W-1:0] flux_q;
	logic [IND_W-1:0]  ld_q;
	logic [IND_W-1:0]  lq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			flux_q <= '0;
			ld_q   <= '0;
			lq_q   <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MODE: mode_q <= cfg_data[0];
				REG_FLUX: flux_q <= cfg_data[FLUX_W-1:0];
				REG_LD:   ld_q   <= cfg_data[IND_W-1:0];
				REG_LQ:   lq_q   <= cfg_data[IND_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s11;
	assign en       = !vld_s11 || out_ready;
	assign in_ready = en;

	// stage 1: magnitude, special cases, scaled flux, inductance difference
	logic             neg_c;
	logic [CUR_W-1:0] mag_c;
	kind_t            kind_c;
	logic [F_W-1:0]   f_c;

	assign neg_c = current_target[CUR_W-1];
	assign mag_c = neg_c ? (~$unsigned(current_target) + 1'b1) : $unsigned(current_target);
	assign f_c   = F_W'(flux_q) * F_W'(FLUX_SCALE);

	always_comb begin
		if (!mode_q || ((|mag_c[CUR_W-1:1]) && ld_q >= lq_q)) begin
			kind_c = K_PASS;
		end else if (!(|mag_c[CUR_W-1:1])) begin
			kind_c = K_ZERO;
		end else begin
			kind_c = K_MTPA;
		end
	end

	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	carry_t car_s1, car_s2, car_s3, car_s4, car_s5, car_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// stages 2..6: F^2 and (dL*Is)^2 from 32-bit partial products, then F^2 + 8*(dL*Is)^2
	logic [2*FH_W-1:0]     ffhh_s2;
	logic [FH_W+31:0]      ffhl_s2;
	logic [63:0]           ffll_s2;
	logic [DH_W+CUR_W-1:0] pdh_s2;
	logic [31+CUR_W:0]     pdl_s2;
	logic [FSQ_W-1:0]      fsq_s3, fsq_s4, fsq_s5;
	logic [P_W-1:0]        p_s3;
	logic [2*PH_W-1:0]     pphh_s4;
	logic [PH_W+31:0]      pphl_s4;
	logic [63:0]           ppll_s4;
	logic [P2_W-1:0]       p2_s5;
	logic [T_W-1:0]        t_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			car_s1.side <= '{neg: neg_c, mag: mag_c, kind: kind_c};
			car_s1.f    <= f_c;
			car_s1.dl   <= lq_q - ld_q;

			car_s2  <= car_s1;
			ffhh_s2 <= car_s1.f[F_W-1:32] * car_s1.f[F_W-1:32];
			ffhl_s2 <= car_s1.f[F_W-1:32] * car_s1.f[31:0];
			ffll_s2 <= car_s1.f[31:0] * car_s1.f[31:0];
			pdh_s2  <= car_s1.dl[IND_W-1:32] * car_s1.side.mag;
			pdl_s2  <= car_s1.dl[31:0] * car_s1.side.mag;

			car_s3 <= car_s2;
			fsq_s3 <= FSQ_W'({ffhh_s2, 64'd0}) + FSQ_W'({ffhl_s2, 33'd0}) + FSQ_W'(ffll_s2);
			p_s3   <= P_W'({pdh_s2, 32'd0}) + P_W'(pdl_s2);

			car_s4  <= car_s3;
			fsq_s4  <= fsq_s3;
			pphh_s4 <= p_s3[P_W-1:32] * p_s3[P_W-1:32];
			pphl_s4 <= p_s3[P_W-1:32] * p_s3[31:0];
			ppll_s4 <= p_s3[31:0] * p_s3[31:0];

			car_s5 <= car_s4;
			fsq_s5 <= fsq_s4;
			p2_s5  <= P2_W'({pphh_s4, 64'd0}) + P2_W'({pphl_s4, 33'd0}) + P2_W'(ppll_s4);

			car_s6 <= car_s5;
			t_s6   <= T_W'({p2_s5, 3'b000}) + T_W'(fsq_s5);
		end
	end

	logic           sq_vld;
	carry_t         sq_car;
	logic [S_W-1:0] sq_root;

	mtpa_wide_sqrt u_wide_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.in_car  (car_s6),
		.rad     (t_s6),
		.out_vld (sq_vld),
		.out_car (sq_car),
		.root    (sq_root)
	);

	// stage 7: numerator s - F
	logic            vld_s7;
	carry_t          car_s7;
	logic [DV_W-1:0] num_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s7 <= sq_car;
			num_s7 <= DV_W'(sq_root - S_W'(sq_car.f));
		end
	end

	// restoring divide by 4*dL, one quotient bit per stage, MSB first
	logic             dv_vld_s [CUR_W];
	carry_t           dv_car_s [CUR_W];
	logic [DV_W-1:0]  dv_rem_s [CUR_W];
	logic [CUR_W-1:0] dv_q_s   [CUR_W];

	for (genvar k = 0; k < CUR_W; k++) begin : g_div
		logic             vi;
		carry_t           ci;
		logic [DV_W-1:0]  ri;
		logic [CUR_W-1:0] qi;
		logic [DV_W-1:0]  den_sh;
		logic             ge;

		if (k == 0) begin : g_first
			assign vi = vld_s7;
			assign ci = car_s7;
			assign ri = num_s7;
			assign qi = '0;
		end else begin : g_next
			assign vi = dv_vld_s[k-1];
			assign ci = dv_car_s[k-1];
			assign ri = dv_rem_s[k-1];
			assign qi = dv_q_s[k-1];
		end

		assign den_sh = DV_W'({ci.dl, 2'b00}) << (CUR_W - 1 - k);
		assign ge     = ri >= den_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_car_s[k] <= ci;
				dv_rem_s[k] <= ge ? ri - den_sh : ri;
				dv_q_s[k]   <= {qi[CUR_W-2:0], ge};
			end
		end
	end

	// stages 8..10: clamp Id, then Is^2 - Id^2
	logic             vld_s8, vld_s9, vld_s10;
	side_t            side_s8, side_s9, side_s10;
	logic [CUR_W-1:0] idm_s8, idm_s9, idm_s10;
	logic [R2_W-1:0]  isq_s9, idsq_s9, rad_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s8  <= dv_vld_s[CUR_W-1];
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= dv_car_s[CUR_W-1].side;
			idm_s8  <= (dv_q_s[CUR_W-1] > dv_car_s[CUR_W-1].side.mag) ?
				dv_car_s[CUR_W-1].side.mag : dv_q_s[CUR_W-1];

			side_s9 <= side_s8;
			idm_s9  <= idm_s8;
			isq_s9  <= side_s8.mag * side_s8.mag;
			idsq_s9 <= idm_s8 * idm_s8;

			side_s10 <= side_s9;
			idm_s10  <= idm_s9;
			rad_s10  <= isq_s9 - idsq_s9;
		end
	end

	// square root of Is^2 - Id^2, one root bit per stage
	logic             rq_vld_s  [CUR_W];
	side_t            rq_side_s [CUR_W];
	logic [CUR_W-1:0] rq_idm_s  [CUR_W];
	logic [R2_W-1:0]  rq_rad_s  [CUR_W];
	logic [RR_W-1:0]  rq_rem_s  [CUR_W];
	logic [CUR_W-1:0] rq_root_s [CUR_W];

	for (genvar k = 0; k < CUR_W; k++) begin : g_rsq
		logic                vi;
		side_t               si;
		logic [CUR_W-1:0]    di;
		logic [R2_W-1:0]     ri;
		logic [RR_W-1:0]     mi;
		logic [CUR_W-1:0]    qi;
		logic [SR_W+S_W-1:0] nx;

		if (k == 0) begin : g_first
			assign vi = vld_s10;
			assign si = side_s10;
			assign di = idm_s10;
			assign ri = rad_s10;
			assign mi = '0;
			assign qi = '0;
		end else begin : g_next
			assign vi = rq_vld_s[k-1];
			assign si = rq_side_s[k-1];
			assign di = rq_idm_s[k-1];
			assign ri = rq_rad_s[k-1];
			assign mi = rq_rem_s[k-1];
			assign qi = rq_root_s[k-1];
		end

		assign nx = sqrt_step(SR_W'(mi), S_W'(qi), ri[R2_W-1 -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rq_vld_s[k] <= 1'b0;
			end else if (en) begin
				rq_vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rq_side_s[k] <= si;
				rq_idm_s[k]  <= di;
				rq_rad_s[k]  <= {ri[R2_W-3:0], 2'b00};
				rq_rem_s[k]  <= nx[S_W +: RR_W];
				rq_root_s[k] <= nx[CUR_W-1:0];
			end
		end
	end

	// stage 11: output register, sign and special cases applied
	side_t            side_l;
	logic [CUR_W-1:0] idm_l;
	logic [CUR_W-1:0] root_l;
	logic [CUR_W-1:0] id_c;
	logic [CUR_W-1:0] iq_c;

	assign side_l = rq_side_s[CUR_W-1];
	assign idm_l  = rq_idm_s[CUR_W-1];
	assign root_l = rq_root_s[CUR_W-1];

	always_comb begin
		case (side_l.kind)
			K_MTPA: begin
				id_c = ~idm_l + 1'b1;
				iq_c = side_l.neg ? (~root_l + 1'b1) : root_l;
			end
			K_PASS: begin
				id_c = '0;
				iq_c = side_l.neg ? (~side_l.mag + 1'b1) : side_l.mag;
			end
			default: begin
				id_c = '0;
				iq_c = '0;
			end
		endcase
	end

	logic signed [CUR_W-1:0] id_s11, iq_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= rq_vld_s[CUR_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s11 <= $signed(id_c);
			iq_s11 <= $signed(iq_c);
		end
	end

	assign out_valid = vld_s11;
	assign id_ref    = id_s11;
	assign iq_ref    = iq_s11;

endmodule
`default_nettype wire

### sv/mtpa_chk.sv
// Port-level checks for the MTPA current reference, bound to the top level.
`default_nettype none
module mtpa_chk
	import mtpa_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [CUR_W-1:0] id_ref,
	input wire logic signed [CUR_W-1:0] iq_ref
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(id_ref) && $stable(iq_ref))
		else $error("output transaction changed while stalled");

	// input side stalls only behind an untaken result
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// d current is never positive
	a_id_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (id_ref[CUR_W-1] || id_ref == '0))
		else $error("positive d current reference");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind mtpa_current_reference mtpa_chk u_mtpa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.id_ref    (id_ref),
	.iq_ref    (iq_ref)
);
`default_nettype wire
